// ===== sv/defp_pkg.sv =====
// Shared types and constants of the digitizer event frame parser.
package defp_pkg;

    localparam int HDR_LEN   = 32;
    localparam int COARSE_NS = 1000;
    localparam int TIME_W    = 34;
    localparam int CFG_IDX_W = 1;
    localparam int Q_DEPTH   = 4;
    localparam int Q_PTR_W   = 2;
    localparam int Q_CNT_W   = 3;

    typedef enum logic [1:0] {
        KIND_HEADER = 2'd0,
        KIND_ADC    = 2'd1,
        KIND_TDC    = 2'd2,
        KIND_END    = 2'd3
    } defp_kind_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ADC_EN = 1'b0,
        CFG_TDC_EN = 1'b1
    } defp_cfg_idx_t;

    typedef struct packed {
        logic [7:0]        trigger_info;
        logic [15:0]       run_id;
        logic [31:0]       trig_count;
        logic [TIME_W-1:0] trigger_time;
        logic [7:0]        module_id;
        logic [7:0]        channel_id;
        logic [31:0]       local_trig_count;
        logic [31:0]       trig_pattern;
        logic [TIME_W-1:0] local_start_time;
    } defp_hdr_t;

    typedef struct packed {
        defp_kind_t  kind;
        defp_hdr_t   hdr;
        logic [11:0] sample_value;
        logic        frame_end;
    } defp_result_t;

    typedef struct packed {
        logic [1:0]   cnt;
        defp_result_t first;
        defp_result_t second;
    } defp_push_t;

endpackage

// ===== sv/defp_parser.sv =====
// Byte offset tracking, header capture, and ADC/TDC result assembly.
module defp_parser (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [defp_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic                             cfg_data,
    input  logic                             accept,
    input  logic [7:0]                       stream_byte,
    output defp_pkg::defp_push_t             push
);
    import defp_pkg::*;

    logic [31:0]  offset_reg, offset_next;
    logic [31:0]  length_reg, length_next;
    logic         adc_en_reg, adc_en_next;
    logic         tdc_en_reg, tdc_en_next;
    defp_hdr_t    hdr_reg, hdr_next;
    logic [7:0]   trig_fine_reg, trig_fine_next;
    logic [23:0]  trig_coarse_reg, trig_coarse_next;
    logic [7:0]   start_fine_reg, start_fine_next;
    logic [23:0]  start_coarse_reg, start_coarse_next;
    logic [7:0]   sample_low_reg, sample_low_next;
    logic [7:0]   tdc_partial_reg, tdc_partial_next;

    logic [31:0]  pay_off;
    logic [31:0]  pay_len;
    logic [31:0]  len_word;
    logic [2:0]   grp;
    logic         in_header;
    logic         is_last;
    logic         hdr_hit;
    logic         adc_hit;
    logic         tdc_hit;
    logic [TIME_W-1:0] trig_time;
    logic [TIME_W-1:0] start_time;
    defp_result_t base_rec;
    defp_result_t first_rec;
    defp_result_t second_rec;
    logic [1:0]   cnt;

    assign pay_off   = offset_reg - 32'(HDR_LEN);
    assign pay_len   = length_reg - 32'(HDR_LEN);
    assign grp       = pay_off[2:0];
    assign in_header = offset_reg < 32'(HDR_LEN);
    assign is_last   = (offset_reg >= 32'(HDR_LEN - 1)) && (offset_reg == length_reg - 32'd1);
    assign len_word  = {stream_byte, length_reg[23:0]};

    assign trig_time  = TIME_W'(trig_coarse_reg) * TIME_W'(COARSE_NS)
                      + TIME_W'({trig_fine_reg, 3'b000});
    assign start_time = TIME_W'(start_coarse_reg) * TIME_W'(COARSE_NS)
                      + TIME_W'({start_fine_reg, 3'b000});

    // config writes
    always_comb
    begin
        adc_en_next = adc_en_reg;
        tdc_en_next = tdc_en_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_ADC_EN: adc_en_next = cfg_data;
                CFG_TDC_EN: tdc_en_next = cfg_data;
                default: ;
            endcase
        end
    end

    // header capture
    always_comb
    begin
        length_next       = length_reg;
        hdr_next          = hdr_reg;
        trig_fine_next    = trig_fine_reg;
        trig_coarse_next  = trig_coarse_reg;
        start_fine_next   = start_fine_reg;
        start_coarse_next = start_coarse_reg;
        if (accept && in_header)
        begin
            case (offset_reg[4:0])
                5'd0:  length_next = {24'd0, stream_byte};
                5'd1:  length_next[15:8] = stream_byte;
                5'd2:  length_next[23:16] = stream_byte;
                5'd3:  length_next = (len_word < 32'(HDR_LEN)) ? 32'(HDR_LEN) : len_word;
                5'd4:  hdr_next.run_id[7:0] = stream_byte;
                5'd5:  hdr_next.run_id[15:8] = stream_byte;
                5'd6:  hdr_next.trigger_info = stream_byte;
                5'd7:  hdr_next.trig_count[7:0] = stream_byte;
                5'd8:  hdr_next.trig_count[15:8] = stream_byte;
                5'd9:  hdr_next.trig_count[23:16] = stream_byte;
                5'd10: hdr_next.trig_count[31:24] = stream_byte;
                5'd11: trig_fine_next = stream_byte;
                5'd12: trig_coarse_next[7:0] = stream_byte;
                5'd13: trig_coarse_next[15:8] = stream_byte;
                5'd14: trig_coarse_next[23:16] = stream_byte;
                5'd15:
                begin
                    hdr_next.module_id    = stream_byte;
                    hdr_next.trigger_time = trig_time;
                end
                5'd16: hdr_next.channel_id = stream_byte;
                5'd17: hdr_next.local_trig_count[7:0] = stream_byte;
                5'd18: hdr_next.local_trig_count[15:8] = stream_byte;
                5'd19: hdr_next.local_trig_count[23:16] = stream_byte;
                5'd20: hdr_next.local_trig_count[31:24] = stream_byte;
                5'd21: hdr_next.trig_pattern[7:0] = stream_byte;
                5'd22: hdr_next.trig_pattern[15:8] = stream_byte;
                5'd23: hdr_next.trig_pattern[23:16] = stream_byte;
                5'd24: hdr_next.trig_pattern[31:24] = stream_byte;
                5'd25: start_fine_next = stream_byte;
                5'd26: start_coarse_next[7:0] = stream_byte;
                5'd27: start_coarse_next[15:8] = stream_byte;
                5'd28: start_coarse_next[23:16] = stream_byte;
                5'd29: hdr_next.local_start_time = start_time;
                default: ;
            endcase
        end
    end

    // payload assembly and result selection
    always_comb
    begin
        sample_low_next  = sample_low_reg;
        tdc_partial_next = tdc_partial_reg;
        hdr_hit = (offset_reg == 32'(HDR_LEN - 1));
        adc_hit = 1'b0;
        tdc_hit = 1'b0;
        if (!in_header)
        begin
            if (!pay_off[0])
            begin
                sample_low_next = stream_byte;
            end
            else
            begin
                adc_hit = adc_en_reg;
            end
            case (grp)
                3'd1: tdc_partial_next = {4'd0, stream_byte[7:4]};
                3'd3: tdc_partial_next = {stream_byte[7:4], tdc_partial_reg[3:0]};
                3'd5: tdc_hit = tdc_en_reg && (pay_len >= 32'd8)
                              && ((pay_off - 32'd5) <= (pay_len - 32'd8));
                default: ;
            endcase
        end
        if (!accept)
        begin
            sample_low_next  = sample_low_reg;
            tdc_partial_next = tdc_partial_reg;
        end
    end

    always_comb
    begin
        base_rec              = '0;
        base_rec.hdr          = hdr_reg;
        base_rec.kind         = KIND_HEADER;
        first_rec             = base_rec;
        second_rec            = base_rec;
        second_rec.kind       = KIND_TDC;
        second_rec.sample_value = {2'b00, stream_byte[5:4], tdc_partial_reg};
        cnt = 2'(hdr_hit || adc_hit) + 2'(tdc_hit);
        if (adc_hit)
        begin
            first_rec.kind         = KIND_ADC;
            first_rec.sample_value = {stream_byte[3:0], sample_low_reg};
        end
        else if (!hdr_hit && tdc_hit)
        begin
            first_rec = second_rec;
        end
        if (is_last)
        begin
            if (cnt == 2'd0)
            begin
                first_rec.kind      = KIND_END;
                first_rec.frame_end = 1'b1;
                cnt                 = 2'd1;
            end
            else if (cnt == 2'd2)
            begin
                second_rec.frame_end = 1'b1;
            end
            else
            begin
                first_rec.frame_end = 1'b1;
            end
        end
        push.cnt    = accept ? cnt : 2'd0;
        push.first  = first_rec;
        push.second = second_rec;
    end

    always_comb
    begin
        offset_next = offset_reg;
        if (accept)
        begin
            offset_next = is_last ? 32'd0 : offset_reg + 32'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            offset_reg <= '0;
            length_reg <= '0;
            adc_en_reg <= 1'b1;
            tdc_en_reg <= 1'b1;
        end
        else
        begin
            offset_reg <= offset_next;
            length_reg <= length_next;
            adc_en_reg <= adc_en_next;
            tdc_en_reg <= tdc_en_next;
        end
    end

    always_ff @(posedge clk)
    begin
        hdr_reg          <= hdr_next;
        trig_fine_reg    <= trig_fine_next;
        trig_coarse_reg  <= trig_coarse_next;
        start_fine_reg   <= start_fine_next;
        start_coarse_reg <= start_coarse_next;
        sample_low_reg   <= sample_low_next;
        tdc_partial_reg  <= tdc_partial_next;
    end

endmodule

// ===== sv/defp_queue.sv =====
// Result queue: takes up to two results per cycle, delivers one per cycle while out_stall is low.
module defp_queue (
    input  logic                   clk,
    input  logic                   rst_n,
    input  defp_pkg::defp_push_t   push,
    output logic                   room,
    output logic                   out_valid,
    input  logic                   out_stall,
    output defp_pkg::defp_result_t head
);
    import defp_pkg::*;

    defp_result_t         mem_reg [Q_DEPTH];
    logic [Q_PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [Q_PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [Q_CNT_W-1:0]   count_reg, count_next;
    logic [Q_PTR_W-1:0]   wr_ptr_plus1;
    logic                 pop;

    assign pop          = out_valid && !out_stall;
    assign out_valid    = (count_reg != '0);
    assign room         = (count_reg <= Q_CNT_W'(Q_DEPTH - 2));
    assign head         = mem_reg[rd_ptr_reg];
    assign wr_ptr_plus1 = wr_ptr_reg + Q_PTR_W'(1);

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + Q_PTR_W'(push.cnt);
        rd_ptr_next = rd_ptr_reg + Q_PTR_W'(pop);
        count_next  = count_reg + Q_CNT_W'(push.cnt) - Q_CNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push.cnt != 2'd0)
        begin
            mem_reg[wr_ptr_reg] <= push.first;
        end
        if (push.cnt == 2'd2)
        begin
            mem_reg[wr_ptr_plus1] <= push.second;
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= Q_CNT_W'(Q_DEPTH))
        else $error("queue count beyond depth");

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        ({1'b0, count_reg} + {2'b00, push.cnt}) <= (Q_CNT_W + 1)'(Q_DEPTH))
        else $error("queue push overflows");

    a_hold_when_stalled: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> (count_reg >= $past(count_reg)))
        else $error("queue lost an entry while stalled");

    a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg != Q_CNT_W'(Q_DEPTH)) |-> (Q_PTR_W'(wr_ptr_reg - rd_ptr_reg)
                                              == count_reg[Q_PTR_W-1:0]))
        else $error("queue pointers disagree with count");

endmodule

// ===== sv/digitizer_event_frame_parser.sv =====
// Top level of the digitizer event frame parser.
// A result is queued when its byte is taken; out_valid offers the queue head in order.
// Bytes are taken one per cycle while in_stall is low; a byte may yield two results.
// Input stall rises when the four-entry result queue has fewer than two free entries.
// Reset (rst_n low, asynchronous): byte offset to frame start, queue empty, both enables set.
module digitizer_event_frame_parser (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [defp_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic                            cfg_data,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic [7:0]                      stream_byte,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic [1:0]                      result_kind,
    output logic [7:0]                      trigger_info,
    output logic [15:0]                     run_id,
    output logic [31:0]                     trig_count,
    output logic [defp_pkg::TIME_W-1:0]     trigger_time,
    output logic [7:0]                      module_id,
    output logic [7:0]                      channel_id,
    output logic [31:0]                     local_trig_count,
    output logic [31:0]                     trig_pattern,
    output logic [defp_pkg::TIME_W-1:0]     local_start_time,
    output logic [11:0]                     sample_value,
    output logic                            frame_end
);
    import defp_pkg::*;

    defp_push_t   push;
    defp_result_t head;
    logic         room;
    logic         accept;

    assign in_stall = !room;
    assign accept   = in_valid && room;

    defp_parser u_parser (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .accept      (accept),
        .stream_byte (stream_byte),
        .push        (push)
    );

    defp_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .room      (room),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .head      (head)
    );

    assign result_kind          = head.kind;
    assign trigger_info         = head.hdr.trigger_info;
    assign run_id               = head.hdr.run_id;
    assign trig_count           = head.hdr.trig_count;
    assign trigger_time         = head.hdr.trigger_time;
    assign module_id            = head.hdr.module_id;
    assign channel_id           = head.hdr.channel_id;
    assign local_trig_count     = head.hdr.local_trig_count;
    assign trig_pattern         = head.hdr.trig_pattern;
    assign local_start_time     = head.hdr.local_start_time;
    assign sample_value         = head.sample_value;
    assign frame_end            = head.frame_end;

endmodule
